[rtl/code128_symbol_encoder_macros.svh]
// Assertion macros shared by the Code 128 encoder RTL.
// Expects a clock named clk and an active-high reset named rst in scope.
`ifndef CODE128_SYMBOL_ENCODER_MACROS_SVH
`define CODE128_SYMBOL_ENCODER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define C128_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define C128_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/c128_pkg.sv]
// Shared types, constants and the symbol pattern table of the Code 128 encoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package c128_pkg;

  // Symbol values and checksum modulus
  localparam int SYM_STOP    = 106;
  localparam int SYM_START_A = 103;
  localparam int CHK_MOD     = 103;
  localparam int NUM_DATA_SYM = 106;

  // Reciprocal of 103 scaled by 2^20, exact for products below 10100
  localparam int RECIP_MUL   = 10181;
  localparam int RECIP_SHIFT = 20;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Item kinds
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  // Code sets
  localparam logic [1:0] SET_A    = 2'd0;
  localparam logic [1:0] SET_B    = 2'd1;
  localparam logic [1:0] SET_C    = 2'd2;
  localparam logic [1:0] SET_NONE = 2'd3;

  // Input word
  typedef struct packed {
    logic       kind;
    logic [7:0] char_first;
    logic [7:0] char_second;
  } in_item_t;

  // Result word
  typedef struct packed {
    logic [6:0]  symbol_value;
    logic [12:0] pattern;
    logic [3:0]  pattern_length;
    logic        last;
    logic        error;
  } out_item_t;

  // Command class handed from front to back
  typedef enum logic [1:0] {
    CMD_DATA,
    CMD_FINISH,
    CMD_ERROR
  } cmd_t;

  // Queue entry
  typedef struct packed {
    cmd_t       cmd;
    logic       with_start;
    logic [6:0] start_sym;
    logic [6:0] sym;
    logic [6:0] contrib;
  } q_entry_t;

  // Back-end expansion step
  typedef enum logic [1:0] {
    STEP_HEAD,
    STEP_BODY,
    STEP_STOP
  } step_t;

  localparam logic [12:0] STOP_PATTERN = 13'b1100011101011;

  localparam logic [10:0] SYM_PATTERNS [0:NUM_DATA_SYM-1] = '{
    11'b11011001100, 11'b11001101100, 11'b11001100110, 11'b10010011000, 11'b10010001100,
    11'b10001001100, 11'b10011001000, 11'b10011000100, 11'b10001100100, 11'b11001001000,
    11'b11001000100, 11'b11000100100, 11'b10110011100, 11'b10011011100, 11'b10011001110,
    11'b10111001100, 11'b10011101100, 11'b10011100110, 11'b11001110010, 11'b11001011100,
    11'b11001001110, 11'b11011100100, 11'b11001110100, 11'b11101101110, 11'b11101001100,
    11'b11100101100, 11'b11100100110, 11'b11101100100, 11'b11100110100, 11'b11100110010,
    11'b11011011000, 11'b11011000110, 11'b11000110110, 11'b10100011000, 11'b10001011000,
    11'b10001000110, 11'b10110001000, 11'b10001101000, 11'b10001100010, 11'b11010001000,
    11'b11000101000, 11'b11000100010, 11'b10110111000, 11'b10110001110, 11'b10001101110,
    11'b10111011000, 11'b10111000110, 11'b10001110110, 11'b11101110110, 11'b11010001110,
    11'b11000101110, 11'b11011101000, 11'b11011100010, 11'b11011101110, 11'b11101011000,
    11'b11101000110, 11'b11100010110, 11'b11101101000, 11'b11101100010, 11'b11100011010,
    11'b11101111010, 11'b11001000010, 11'b11110001010, 11'b10100110000, 11'b10100001100,
    11'b10010110000, 11'b10010000110, 11'b10000101100, 11'b10000100110, 11'b10110010000,
    11'b10110000100, 11'b10011010000, 11'b10011000010, 11'b10000110100, 11'b10000110010,
    11'b11000010010, 11'b11001010000, 11'b11110111010, 11'b11000010100, 11'b10001111010,
    11'b10100111100, 11'b10010111100, 11'b10010011110, 11'b10111100100, 11'b10011110100,
    11'b10011110010, 11'b11110100100, 11'b11110010100, 11'b11110010010, 11'b11011011110,
    11'b11011110110, 11'b11110110110, 11'b10101111000, 11'b10100011110, 11'b10001011110,
    11'b10111101000, 11'b10111100010, 11'b11110101000, 11'b11110100010, 11'b10111011110,
    11'b10111101110, 11'b11101011110, 11'b11110101110, 11'b11010000100, 11'b11010010000,
    11'b11010011100
  };

  // Module pattern of a symbol, first module in the top used bit
  function automatic logic [12:0] sym_pattern(input logic [6:0] sym);
    logic [12:0] pat;
    if (sym == 7'(SYM_STOP)) begin
      pat = STOP_PATTERN;
    end else if (sym < 7'(NUM_DATA_SYM)) begin
      pat = {2'b00, SYM_PATTERNS[sym]};
    end else begin
      pat = '0;
    end
    return pat;
  endfunction

endpackage

[rtl/c128_front.sv]
// Front end: code set register, character mapping, message tracking and checksum terms.
// Depends on c128_pkg; feeds c128_queue.
`timescale 1ns / 1ps

module c128_front
  import c128_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // input channel
  input  logic       item_valid,
  output logic       item_ready,
  input  in_item_t   item,
  // configuration
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_data,
  // queue write side
  output logic       q_wr_valid,
  input  logic       q_wr_ready,
  output q_entry_t   q_wr_entry
);

  logic [1:0] code_set;
  logic       in_message;
  logic [6:0] pos_weight;

  // stage A: classified word
  logic       a_valid;
  cmd_t       a_cmd;
  logic       a_with_start;
  logic [6:0] a_start_sym;
  logic [6:0] a_sym;
  logic [6:0] a_weight;

  // stage B: weighted product
  logic        b_valid;
  cmd_t        b_cmd;
  logic        b_with_start;
  logic [6:0]  b_start_sym;
  logic [6:0]  b_sym;
  logic [13:0] b_prod;

  logic        advance;
  logic        accept;
  logic        char_ok;
  logic [6:0]  char_val;
  logic [3:0]  digit_hi;
  logic [3:0]  digit_lo;
  cmd_t        cls_cmd;
  logic        cls_with_start;
  logic [6:0]  cls_sym;
  logic [6:0]  cls_weight;
  logic        in_message_next;
  logic [6:0]  pos_weight_next;
  logic [27:0] recip_prod;
  logic [7:0]  quot;
  logic [13:0] rem;

  assign advance    = !b_valid || q_wr_ready;
  assign item_ready = advance;
  assign accept     = item_valid && item_ready;
  assign cfg_ready  = 1'b1;

  // Code set register; the unused code is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      code_set <= SET_B;
    end else if (cfg_valid && cfg_ready && cfg_data != SET_NONE) begin
      code_set <= cfg_data;
    end
  end

  // Map the character bytes to a symbol value for the current set
  always_comb begin
    digit_hi = item.char_first[3:0];
    digit_lo = item.char_second[3:0];
    char_ok  = 1'b0;
    char_val = '0;
    case (code_set)
      SET_A: begin
        if (item.char_first inside {[8'h20:8'h5F]}) begin
          char_ok  = 1'b1;
          char_val = 7'(item.char_first - 8'h20);
        end else if (item.char_first <= 8'h1F) begin
          char_ok  = 1'b1;
          char_val = 7'(item.char_first + 8'd64);
        end
      end
      SET_B: begin
        if (item.char_first inside {[8'h20:8'h7F]}) begin
          char_ok  = 1'b1;
          char_val = 7'(item.char_first - 8'h20);
        end
      end
      SET_C: begin
        if (item.char_first inside {[8'h30:8'h39]} &&
            item.char_second inside {[8'h30:8'h39]}) begin
          char_ok  = 1'b1;
          char_val = 7'({digit_hi, 3'b000}) + 7'({digit_hi, 1'b0}) + 7'(digit_lo);
        end
      end
      default: begin
        char_ok = 1'b0;
      end
    endcase
  end

  // Classify the word and advance the message state
  always_comb begin
    cls_cmd         = CMD_ERROR;
    cls_with_start  = 1'b0;
    cls_sym         = '0;
    cls_weight      = '0;
    in_message_next = 1'b0;
    pos_weight_next = '0;
    if (item.kind == KIND_FINISH) begin
      cls_cmd        = CMD_FINISH;
      cls_with_start = !in_message;
    end else if (char_ok) begin
      cls_cmd        = CMD_DATA;
      cls_with_start = !in_message;
      cls_sym        = char_val;
      if (!in_message) begin
        pos_weight_next = 7'd1;
      end else if (pos_weight == 7'(CHK_MOD - 1)) begin
        pos_weight_next = '0;
      end else begin
        pos_weight_next = pos_weight + 7'd1;
      end
      cls_weight      = pos_weight_next;
      in_message_next = 1'b1;
    end
  end

  // Message state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_message <= 1'b0;
      pos_weight <= '0;
    end else if (accept) begin
      in_message <= in_message_next;
      pos_weight <= pos_weight_next;
    end
  end

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else if (advance) begin
      a_valid <= accept;
      b_valid <= a_valid;
    end
  end

  // Pipeline payload: classify, then multiply symbol by weight
  always_ff @(posedge clk) begin
    if (advance) begin
      a_cmd        <= cls_cmd;
      a_with_start <= cls_with_start;
      a_start_sym  <= 7'(SYM_START_A) + 7'(code_set);
      a_sym        <= cls_sym;
      a_weight     <= cls_weight;
      b_cmd        <= a_cmd;
      b_with_start <= a_with_start;
      b_start_sym  <= a_start_sym;
      b_sym        <= a_sym;
      b_prod       <= 14'(a_sym) * 14'(a_weight);
    end
  end

  // Reduce the product modulo 103 by reciprocal multiplication
  assign recip_prod = 28'(b_prod) * 28'(RECIP_MUL);
  assign quot       = recip_prod[RECIP_SHIFT +: 8];
  assign rem        = b_prod - 14'(quot) * 14'(CHK_MOD);

  assign q_wr_valid            = b_valid;
  assign q_wr_entry.cmd        = b_cmd;
  assign q_wr_entry.with_start = b_with_start;
  assign q_wr_entry.start_sym  = b_start_sym;
  assign q_wr_entry.sym        = b_sym;
  assign q_wr_entry.contrib    = rem[6:0];

endmodule

[rtl/c128_queue.sv]
// Short FIFO of classified words between the front and back ends.
// Depends on c128_pkg for the entry type and depth.
`timescale 1ns / 1ps

module c128_queue
  import c128_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     wr_valid,
  output logic     wr_ready,
  input  q_entry_t wr_entry,
  output logic     rd_valid,
  input  logic     rd_ready,
  output q_entry_t rd_entry
);

  q_entry_t                entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]  wr_ptr;
  logic [QUEUE_PTR_W-1:0]  rd_ptr;
  logic [QUEUE_CNT_W-1:0]  count;
  logic                    push;
  logic                    pop;

  assign wr_ready = count != QUEUE_CNT_W'(QUEUE_DEPTH);
  assign rd_valid = count != '0;
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_entry = entries[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store the incoming entry
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_entry;
    end
  end

endmodule

[rtl/c128_back.sv]
// Back end: expands each classified word into start, data, check, stop or error results.
// Depends on c128_pkg; reads c128_queue and drives the result register.
`timescale 1ns / 1ps

module c128_back
  import c128_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  // queue read side
  input  logic      q_rd_valid,
  output logic      q_rd_ready,
  input  q_entry_t  q_rd_entry,
  // result channel
  output logic      result_valid,
  input  logic      result_ready,
  output out_item_t result
);

  step_t      step;
  step_t      step_next;
  logic [6:0] check_sum;
  logic [6:0] check_sum_next;
  logic       load;
  logic       emit;
  logic [6:0] emit_sym;
  logic       emit_last;
  logic       emit_error;
  logic [7:0] sum_wide;
  logic [6:0] sum_mod;
  out_item_t  result_next;

  assign load = q_rd_valid && (!result_valid || result_ready);

  // Running checksum plus this data term, folded back below 103
  assign sum_wide = 8'(check_sum) + 8'(q_rd_entry.contrib);
  assign sum_mod  = (sum_wide >= 8'(CHK_MOD)) ? 7'(sum_wide - 8'(CHK_MOD)) : sum_wide[6:0];

  // Step register and checksum
  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= STEP_HEAD;
      check_sum <= '0;
    end else begin
      step      <= step_next;
      check_sum <= check_sum_next;
    end
  end

  // Pick the next result of the head entry
  always_comb begin
    step_next      = step;
    check_sum_next = check_sum;
    q_rd_ready     = 1'b0;
    emit           = 1'b0;
    emit_sym       = '0;
    emit_last      = 1'b0;
    emit_error     = 1'b0;
    if (load) begin
      if (step == STEP_HEAD && q_rd_entry.with_start) begin
        emit           = 1'b1;
        emit_sym       = q_rd_entry.start_sym;
        check_sum_next = q_rd_entry.start_sym - 7'(SYM_START_A);
        step_next      = STEP_BODY;
      end else if (step == STEP_STOP) begin
        emit           = 1'b1;
        emit_sym       = 7'(SYM_STOP);
        emit_last      = 1'b1;
        check_sum_next = '0;
        q_rd_ready     = 1'b1;
        step_next      = STEP_HEAD;
      end else begin
        case (q_rd_entry.cmd)
          CMD_DATA: begin
            emit           = 1'b1;
            emit_sym       = q_rd_entry.sym;
            check_sum_next = sum_mod;
            q_rd_ready     = 1'b1;
            step_next      = STEP_HEAD;
          end
          CMD_FINISH: begin
            emit      = 1'b1;
            emit_sym  = check_sum;
            step_next = STEP_STOP;
          end
          CMD_ERROR: begin
            emit           = 1'b1;
            emit_last      = 1'b1;
            emit_error     = 1'b1;
            check_sum_next = '0;
            q_rd_ready     = 1'b1;
            step_next      = STEP_HEAD;
          end
          default: begin
            q_rd_ready = 1'b1;
            step_next  = STEP_HEAD;
          end
        endcase
      end
    end
  end

  // Build the result word
  always_comb begin
    result_next.symbol_value = emit_sym;
    result_next.last         = emit_last;
    result_next.error        = emit_error;
    if (emit_error) begin
      result_next.pattern        = '0;
      result_next.pattern_length = '0;
    end else begin
      result_next.pattern        = sym_pattern(emit_sym);
      result_next.pattern_length = (emit_sym == 7'(SYM_STOP)) ? 4'd13 : 4'd11;
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load && emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (load && emit) begin
      result <= result_next;
    end
  end

endmodule

[rtl/code128_symbol_encoder.sv]
// Code 128 symbol encoder: one data or finish word per cycle in unless stalled, module
// patterns out. The front end classifies words, accepting one per cycle unless the queue
// is full, through stages A and B into a four-entry queue; the back end emits one result
// per cycle from the result register while result_ready is high, so a data word gives one
// result, a first data word two (start plus data) and a finish word two or three (optional
// start, check, stop). Sustained input rate is therefore one word per cycle for data
// inside a message, set by the single-result-per-cycle back end when start, check and stop
// symbols are added. code_set may be written any time the block is idle; a write of 3 is
// ignored. Invalid characters give one error result with last set and abort the message.
`timescale 1ns / 1ps
`include "code128_symbol_encoder_macros.svh"

module code128_symbol_encoder
  import c128_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  in_item_t   item,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_data,
  output logic       result_valid,
  input  logic       result_ready,
  output out_item_t  result
);

  logic     q_wr_valid;
  logic     q_wr_ready;
  q_entry_t q_wr_entry;
  logic     q_rd_valid;
  logic     q_rd_ready;
  q_entry_t q_rd_entry;

  logic     err_seen;
  logic     err_shape;
  logic     stop_seen;
  logic     stop_shape;
  logic     finish_pop;
  logic     stop_loaded;

  c128_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .q_wr_valid (q_wr_valid),
    .q_wr_ready (q_wr_ready),
    .q_wr_entry (q_wr_entry)
  );

  c128_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (q_wr_valid),
    .wr_ready (q_wr_ready),
    .wr_entry (q_wr_entry),
    .rd_valid (q_rd_valid),
    .rd_ready (q_rd_ready),
    .rd_entry (q_rd_entry)
  );

  c128_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_rd_valid   (q_rd_valid),
    .q_rd_ready   (q_rd_ready),
    .q_rd_entry   (q_rd_entry),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // Terms of the checks below
  assign err_seen    = result_valid && result.error;
  assign err_shape   = result.last && result.symbol_value == 7'd0 &&
                       result.pattern_length == 4'd0;
  assign stop_seen   = result_valid && result.last && !result.error;
  assign stop_shape  = result.symbol_value == 7'(SYM_STOP) && result.pattern_length == 4'd13;
  assign finish_pop  = q_rd_valid && q_rd_ready && q_rd_entry.cmd == CMD_FINISH;
  assign stop_loaded = result_valid && result.last && result.symbol_value == 7'(SYM_STOP);

  // An error result closes the message and carries no symbol
  `C128_ASSERT_SAME(a_error_closes, err_seen, err_shape, "error result malformed")

  // A last result without error is always the stop symbol
  `C128_ASSERT_SAME(a_last_is_stop, stop_seen, stop_shape, "last result is not stop")

  // Retiring a finish word loads the stop symbol
  `C128_ASSERT_NEXT(a_finish_stop, finish_pop, stop_loaded, "finish retired without stop")

endmodule

[verif/code128_symbol_encoder_tb.sv]
// Self-checking testbench for code128_symbol_encoder: directed and random messages in all sets.
// Depends on c128_pkg (port types, set and kind codes) and the encoder RTL; reads no files.
`timescale 1ns / 1ps

module code128_symbol_encoder_tb
  import c128_pkg::*;
();

  localparam int    HALF_PERIOD    = 10;
  localparam int    RESET_CYCLES   = 11;
  localparam int    ITEM_TARGET    = 200;
  localparam int    CALM_ITEMS     = 40;
  localparam int    HOLD_CYCLES    = 300;
  localparam int    WATCHDOG_LIMIT = 3000;
  localparam int    SETTLE_CYCLES  = 30;
  localparam int    CFG_PAUSE      = 8;
  localparam byte   DIGIT_0        = 8'h30;
  localparam byte   DIGIT_9        = 8'h39;
  localparam logic [12:0] STOP_BARS = 13'b1100011101011;

  // Bar/space modules of symbols 0..105, first module in bit 10
  localparam logic [10:0] BAR_TABLE [0:105] = '{
    11'b11011001100, 11'b11001101100, 11'b11001100110, 11'b10010011000, 11'b10010001100,
    11'b10001001100, 11'b10011001000, 11'b10011000100, 11'b10001100100, 11'b11001001000,
    11'b11001000100, 11'b11000100100, 11'b10110011100, 11'b10011011100, 11'b10011001110,
    11'b10111001100, 11'b10011101100, 11'b10011100110, 11'b11001110010, 11'b11001011100,
    11'b11001001110, 11'b11011100100, 11'b11001110100, 11'b11101101110, 11'b11101001100,
    11'b11100101100, 11'b11100100110, 11'b11101100100, 11'b11100110100, 11'b11100110010,
    11'b11011011000, 11'b11011000110, 11'b11000110110, 11'b10100011000, 11'b10001011000,
    11'b10001000110, 11'b10110001000, 11'b10001101000, 11'b10001100010, 11'b11010001000,
    11'b11000101000, 11'b11000100010, 11'b10110111000, 11'b10110001110, 11'b10001101110,
    11'b10111011000, 11'b10111000110, 11'b10001110110, 11'b11101110110, 11'b11010001110,
    11'b11000101110, 11'b11011101000, 11'b11011100010, 11'b11011101110, 11'b11101011000,
    11'b11101000110, 11'b11100010110, 11'b11101101000, 11'b11101100010, 11'b11100011010,
    11'b11101111010, 11'b11001000010, 11'b11110001010, 11'b10100110000, 11'b10100001100,
    11'b10010110000, 11'b10010000110, 11'b10000101100, 11'b10000100110, 11'b10110010000,
    11'b10110000100, 11'b10011010000, 11'b10011000010, 11'b10000110100, 11'b10000110010,
    11'b11000010010, 11'b11001010000, 11'b11110111010, 11'b11000010100, 11'b10001111010,
    11'b10100111100, 11'b10010111100, 11'b10010011110, 11'b10111100100, 11'b10011110100,
    11'b10011110010, 11'b11110100100, 11'b11110010100, 11'b11110010010, 11'b11011011110,
    11'b11011110110, 11'b11110110110, 11'b10101111000, 11'b10100011110, 11'b10001011110,
    11'b10111101000, 11'b10111100010, 11'b11110101000, 11'b11110100010, 11'b10111011110,
    11'b10111101110, 11'b11101011110, 11'b11110101110, 11'b11010000100, 11'b11010010000,
    11'b11010011100
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_ready;
  in_item_t   item = '0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_data = SET_B;
  logic       result_valid;
  logic       result_ready = 1'b1;
  out_item_t  result;

  // Encoder shadow state
  logic [1:0] set_now;
  bit         msg_open;
  int         chk_acc;
  int         weight_acc;
  out_item_t  symbol_q[$];

  int         items_sent = 0;
  int         errors = 0;
  bit         gaps_on = 1'b1;
  bit         stalls_on = 1'b1;
  logic       hold_go = 1'b0;
  logic       hold_done = 1'b0;
  int         hold_cnt = 0;
  int         stall_left = 0;
  int         quiet_cycles = 0;
  out_item_t  want;

  code128_symbol_encoder dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  // Symbol value of a data word in the given set, -1 when invalid
  function automatic int char_value(logic [1:0] cs, logic [7:0] a, logic [7:0] b);
    int v;
    v = -1;
    case (cs)
      SET_A: begin
        if (a >= 8'h20 && a <= 8'h5F) v = a - 8'h20;
        else if (a <= 8'h1F) v = a + 64;
      end
      SET_B: begin
        if (a >= 8'h20 && a <= 8'h7F) v = a - 8'h20;
      end
      default: begin
        if (a >= DIGIT_0 && a <= DIGIT_9 && b >= DIGIT_0 && b <= DIGIT_9)
          v = (a - DIGIT_0) * 10 + (b - DIGIT_0);
      end
    endcase
    return v;
  endfunction

  function automatic out_item_t symbol_word(int sym, logic fin);
    out_item_t w;
    w = '0;
    w.symbol_value = 7'(sym);
    if (sym == SYM_STOP) begin
      w.pattern        = STOP_BARS;
      w.pattern_length = 4'd13;
    end else begin
      w.pattern        = {2'b00, BAR_TABLE[sym]};
      w.pattern_length = 4'd11;
    end
    w.last = fin;
    return w;
  endfunction

  function automatic void close_message();
    msg_open   = 1'b0;
    chk_acc    = 0;
    weight_acc = 0;
  endfunction

  // Emit the start symbol and seed the checksum with it
  function automatic void open_message();
    int start_sym;
    start_sym = SYM_START_A + set_now;
    symbol_q.push_back(symbol_word(start_sym, 1'b0));
    msg_open   = 1'b1;
    chk_acc    = start_sym % CHK_MOD;
    weight_acc = 0;
  endfunction

  // Queue the results that one accepted word produces
  function automatic void encode_expected(in_item_t w);
    int v;
    out_item_t bad;
    if (w.kind == KIND_FINISH) begin
      if (!msg_open) open_message();
      symbol_q.push_back(symbol_word(chk_acc, 1'b0));
      symbol_q.push_back(symbol_word(SYM_STOP, 1'b1));
      close_message();
    end else begin
      v = char_value(set_now, w.char_first, w.char_second);
      if (v < 0) begin
        bad = '0;
        bad.last  = 1'b1;
        bad.error = 1'b1;
        symbol_q.push_back(bad);
        close_message();
      end else begin
        if (!msg_open) open_message();
        weight_acc = (weight_acc + 1) % CHK_MOD;
        chk_acc    = (chk_acc + v * weight_acc) % CHK_MOD;
        symbol_q.push_back(symbol_word(v, 1'b0));
      end
    end
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic in_item_t data_word(logic [7:0] a, logic [7:0] b);
    in_item_t w;
    w.kind        = KIND_DATA;
    w.char_first  = a;
    w.char_second = b;
    return w;
  endfunction

  function automatic in_item_t finish_word();
    in_item_t w;
    w.kind        = KIND_FINISH;
    w.char_first  = 8'($urandom_range(0, 255));
    w.char_second = 8'($urandom_range(0, 255));
    return w;
  endfunction

  // Random valid character for the current set
  function automatic in_item_t valid_word();
    in_item_t w;
    case (set_now)
      SET_A:   w = data_word(8'($urandom_range(0, 8'h5F)), 8'($urandom_range(0, 255)));
      SET_B:   w = data_word(8'($urandom_range(8'h20, 8'h7F)), 8'($urandom_range(0, 255)));
      default: w = data_word(8'(DIGIT_0 + $urandom_range(0, 9)),
                             8'(DIGIT_0 + $urandom_range(0, 9)));
    endcase
    return w;
  endfunction

  // Offer one word, hold it until accepted, then predict its results
  task automatic send_item(in_item_t w);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= w;
    do @(posedge clk); while (!item_ready);
    encode_expected(w);
    items_sent++;
  endtask

  task automatic drain_results();
    item_valid <= 1'b0;
    while (symbol_q.size() != 0) @(posedge clk);
  endtask

  // Write code_set once the block has delivered everything
  task automatic write_code_set(logic [1:0] v);
    drain_results();
    repeat (CFG_PAUSE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (v != SET_NONE) set_now = v;
  endtask

  // ---------------------------------------------------------------- tests

  // Empty message and a one-character message in the reset set
  task automatic test_reset_set();
    send_item(finish_word());
    send_item(data_word(8'h41, 8'hFF));
    send_item(finish_word());
  endtask

  // Range edges of set A and set B, with invalid bytes aborting a message
  task automatic test_set_ab_edges();
    write_code_set(SET_A);
    send_item(data_word(8'h00, 8'h00));
    send_item(data_word(8'h1F, 8'hFF));
    send_item(data_word(8'h20, 8'h5A));
    send_item(data_word(8'h5F, 8'hA5));
    send_item(data_word(8'h60, 8'h00));
    send_item(data_word(8'h41, 8'h00));
    send_item(finish_word());
    write_code_set(SET_B);
    send_item(data_word(8'h20, 8'h00));
    send_item(data_word(8'h7F, 8'hFF));
    send_item(data_word(8'h80, 8'h00));
    send_item(data_word(8'h1F, 8'h00));
    send_item(data_word(8'hFF, 8'h30));
    send_item(data_word(8'h7F, 8'h00));
    send_item(finish_word());
  endtask

  // Digit pairs of set C, including non-digit bytes on either side
  task automatic test_set_c_pairs();
    write_code_set(SET_C);
    send_item(data_word(DIGIT_0, DIGIT_0));
    send_item(data_word(DIGIT_9, DIGIT_9));
    send_item(finish_word());
    send_item(data_word(DIGIT_9, 8'h3A));
    send_item(data_word(8'h2F, DIGIT_0));
    send_item(data_word(8'hFF, 8'h35));
  endtask

  // Unused code and a set change in the middle of an open message
  task automatic test_set_switch();
    write_code_set(SET_NONE);
    send_item(data_word(DIGIT_0 + 8'd4, DIGIT_0 + 8'd2));
    write_code_set(SET_A);
    send_item(data_word(8'h05, 8'h00));
    send_item(finish_word());
  endtask

  // More than 103 data words so the position weight wraps
  task automatic test_long_message();
    write_code_set(SET_B);
    repeat (110) send_item(valid_word());
    send_item(finish_word());
  endtask

  // Stop the receiver for a long stretch while words keep coming
  task automatic test_backpressure();
    hold_go <= 1'b1;
    repeat (20) send_item(valid_word());
    send_item(finish_word());
    while (!hold_done) @(posedge clk);
    hold_go <= 1'b0;
  endtask

  // Random messages, mostly well formed, with noise and unfinished ones
  task automatic test_random_messages(int target);
    int len;
    while (items_sent < target) begin
      if ($urandom_range(0, 4) == 0) write_code_set(2'($urandom_range(0, 3)));
      len = $urandom_range(0, 10);
      repeat (len) begin
        if ($urandom_range(0, 14) == 0)
          send_item(data_word(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))));
        else
          send_item(valid_word());
      end
      if ($urandom_range(0, 7) != 0) send_item(finish_word());
    end
  endtask

  // ---------------------------------------------------------------- sequencing

  initial begin
    set_now = SET_B;
    close_message();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_reset_set();
    test_set_ab_edges();
    test_set_c_pairs();
    test_set_switch();
    test_long_message();
    test_backpressure();
    test_random_messages(ITEM_TARGET - CALM_ITEMS);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    test_random_messages(ITEM_TARGET);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (symbol_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("code128_symbol_encoder regression: pass");
    end else begin
      $display("code128_symbol_encoder regression: fail");
    end
    $finish;
  end

  // ---------------------------------------------------------------- receiver

  // Hold off on request, otherwise stall in random bursts
  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      result_ready <= 1'b0;
      hold_cnt     <= hold_cnt + 1;
      if (hold_cnt == HOLD_CYCLES - 1) hold_done <= 1'b1;
    end else begin
      if (!hold_go) begin
        hold_done <= 1'b0;
        hold_cnt  <= 0;
      end
      if (stall_left != 0) begin
        result_ready <= 1'b0;
        stall_left   <= stall_left - 1;
      end else if (stalls_on && $urandom_range(0, 4) == 0) begin
        result_ready <= 1'b0;
        stall_left   <= $urandom_range(0, 6);
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- checker

  function automatic void check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Compare each result word with the oldest expected symbol
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (symbol_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, result);
        errors++;
      end else begin
        want = symbol_q.pop_front();
        check_field("symbol_value", want.symbol_value, result.symbol_value);
        check_field("pattern", want.pattern, result.pattern);
        check_field("pattern_length", want.pattern_length, result.pattern_length);
        check_field("last", want.last, result.last);
        check_field("error", want.error, result.error);
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  // Count cycles without any handshake and give up past the limit
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("code128_symbol_encoder regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

[files.f]
+incdir+rtl
rtl/c128_pkg.sv
rtl/c128_front.sv
rtl/c128_queue.sv
rtl/c128_back.sv
rtl/code128_symbol_encoder.sv
verif/code128_symbol_encoder_tb.sv
